[rtl/swmf_pkg.sv]
// Shared types, sizes and operation codes for the sliding window median filter.
// No dependencies; used by swmf_cell and sliding_window_median_filter_unit.
`default_nettype none

package swmf_pkg;

    // Sizes
    localparam int MAX_HALF_WINDOW = 16;
    localparam int SAMPLE_BITS     = 24;
    localparam int SLOTS           = 2 * MAX_HALF_WINDOW + 1;
    localparam int IDX_W           = $clog2(SLOTS + 1);
    localparam int AGE_W           = 6;
    localparam int HALF_W          = 5;
    localparam int HALF_RESET      = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [AGE_W-1:0]              age_t;
    typedef logic [HALF_W-1:0]             half_t;
    typedef logic [1:0]                    op_t;

    localparam age_t AGE_MAX = '1;

    // Operation broadcast to every cell
    localparam op_t OP_IDLE   = 2'd0;
    localparam op_t OP_FILTER = 2'd1;
    localparam op_t OP_PRIME  = 2'd2;
    localparam op_t OP_INIT   = 2'd3;

    // Broadcast control: operation, new sample and index of the last window slot
    typedef struct packed {
        op_t     op;
        sample_t sample;
        idx_t    last_idx;
    } ctrl_t;

    // Handed from cell j to cell j+1: compacted entry, insert flag, eviction seen
    typedef struct packed {
        sample_t val;
        age_t    age;
        logic    gt;
        logic    seen;
    } link_t;

endpackage

`default_nettype wire

[rtl/swmf_cell.sv]
// One slot of the sorted window: holds a sample and its age, and on each update
// evicts, compacts and inserts using only its two neighbours. Depends on swmf_pkg.
`default_nettype none

module swmf_cell (
    input  wire logic            clk,
    input  wire swmf_pkg::ctrl_t ctrl,
    input  wire swmf_pkg::idx_t  slot_idx,
    input  wire swmf_pkg::sample_t up_val,
    input  wire swmf_pkg::age_t  up_age,
    input  wire swmf_pkg::link_t lo_link,
    output swmf_pkg::link_t      link,
    output swmf_pkg::sample_t    val,
    output swmf_pkg::age_t       age,
    output logic                 evict
);
    import swmf_pkg::*;

    sample_t val_reg, val_next;
    age_t    age_reg, age_next;
    logic    active, is_last, seen, gt;
    sample_t c_val;
    age_t    c_age, c_age_inc;

    // Slot position within the current window
    assign active  = (slot_idx <= ctrl.last_idx);
    assign is_last = (slot_idx == ctrl.last_idx);

    // Oldest sample has age equal to window length minus one
    assign evict = active && (age_reg == age_t'(ctrl.last_idx));
    assign seen  = lo_link.seen | evict;

    // Entry of this slot once the oldest one has been removed, aged by one
    assign c_val     = seen ? up_val : val_reg;
    assign c_age     = seen ? up_age : age_reg;
    assign c_age_inc = (c_age == AGE_MAX) ? c_age : c_age + age_t'(1);

    // New sample goes above this compacted entry when strictly greater or in the last slot
    assign gt = is_last || !active ||
                (seen ? ($signed(ctrl.sample) > $signed(up_val))
                      : ($signed(ctrl.sample) > $signed(val_reg)));

    assign link = '{val: c_val, age: c_age_inc, gt: gt, seen: seen};

    // Next slot contents
    always_comb
    begin
        val_next = val_reg;
        age_next = age_reg;
        case (ctrl.op)
            OP_FILTER:
            begin
                if (active)
                begin
                    if (lo_link.gt)
                    begin
                        val_next = lo_link.val;
                        age_next = lo_link.age;
                    end
                    else if (gt)
                    begin
                        val_next = ctrl.sample;
                        age_next = '0;
                    end
                    else
                    begin
                        val_next = c_val;
                        age_next = c_age_inc;
                    end
                end
            end
            OP_PRIME, OP_INIT:
            begin
                if (active)
                begin
                    val_next = (ctrl.op == OP_PRIME) ? ctrl.sample : '0;
                    age_next = age_t'(ctrl.last_idx - slot_idx);
                end
                else
                begin
                    val_next = '0;
                    age_next = '0;
                end
            end
            default:
            begin
                val_next = val_reg;
                age_next = age_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

`default_nettype wire

[rtl/sliding_window_median_filter_unit.sv]
// Top level of the running median filter: configuration, handshakes and the
// chain of swmf_cell slots. Depends on swmf_pkg and swmf_cell.
//
// Running median over a window of 2*half_window+1 signed 24-bit samples
// (half_window saturates at 16, so at most 33 slots). func = 0 filters the
// sample: the oldest sample leaves, the new one is inserted in sorted order
// (below equal values) and the median is returned. func = 1 primes the whole
// window with the sample and returns it. Every transaction gives one result,
// in the cycle after acceptance; a new transaction is taken in the cycle the
// result is taken, so while out_ready stays high the sustained rate is one item
// per clock. After reset the chain initialises before in_ready rises. Writing
// cfg_data resets the window to zeros at the new length in that cycle; prime it
// afterwards.
`default_nettype none

module sliding_window_median_filter_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire swmf_pkg::sample_t sample,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output swmf_pkg::sample_t      median,
    input  wire logic              cfg_we,
    input  wire swmf_pkg::half_t   cfg_data
);
    import swmf_pkg::*;

    half_t   hw_reg;
    logic    init_pend_reg;
    logic    out_valid_reg;
    half_t   hw_sel, eff_sel, eff_cur;
    logic    accept;
    ctrl_t   ctrl;
    link_t   links    [SLOTS];
    sample_t vals     [SLOTS];
    age_t    ages     [SLOTS];
    logic [SLOTS-1:0] evict_vec;

    // Handshake
    assign in_ready  = !init_pend_reg && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Effective half window, for the value being written or the stored one
    assign hw_sel  = cfg_we ? cfg_data : hw_reg;
    assign eff_sel = (hw_sel > half_t'(MAX_HALF_WINDOW)) ? half_t'(MAX_HALF_WINDOW) : hw_sel;
    assign eff_cur = (hw_reg > half_t'(MAX_HALF_WINDOW)) ? half_t'(MAX_HALF_WINDOW) : hw_reg;

    // Broadcast control
    always_comb
    begin
        ctrl.sample   = sample;
        ctrl.last_idx = idx_t'({eff_sel, 1'b0});
        if (cfg_we || init_pend_reg)
            ctrl.op = OP_INIT;
        else if (accept)
            ctrl.op = func ? OP_PRIME : OP_FILTER;
        else
            ctrl.op = OP_IDLE;
    end

    // Slot chain
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_slot
        sample_t up_val;
        age_t    up_age;
        link_t   lo_link;

        if (j + 1 < SLOTS)
        begin : g_up
            assign up_val = vals[j+1];
            assign up_age = ages[j+1];
        end
        else
        begin : g_top
            assign up_val = '0;
            assign up_age = '0;
        end

        if (j > 0)
        begin : g_lo
            assign lo_link = links[j-1];
        end
        else
        begin : g_first
            assign lo_link = '0;
        end

        swmf_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .slot_idx (idx_t'(j)),
            .up_val   (up_val),
            .up_age   (up_age),
            .lo_link  (lo_link),
            .link     (links[j]),
            .val      (vals[j]),
            .age      (ages[j]),
            .evict    (evict_vec[j])
        );
    end

    // Median is the slot at rank half from the top
    assign median = vals[idx_t'(eff_cur)];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg        <= half_t'(HALF_RESET);
            init_pend_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                hw_reg <= cfg_data;
            init_pend_reg <= 1'b0;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Checks
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("no result after accepted transaction");

    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        init_pend_reg |-> !in_ready)
        else $error("input taken during initialisation");

    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_FILTER |-> $onehot(evict_vec))
        else $error("oldest slot not unique");

    a_prime_value: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func && !cfg_we |=> median == $past(sample))
        else $error("prime result differs from sample");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for sliding_window_median_filter_unit: directed and random
// transactions checked against an in-bench running median model.
// Depends on rtl/swmf_pkg.sv and rtl/sliding_window_median_filter_unit.sv.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swmf_pkg::*;

    // Function codes of the input transaction
    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_PRIME  = 1'b1;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int      RANDOM_ITEMS = 1750;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    func      = FUNC_FILTER;
    sample_t sample    = '0;
    logic    out_ready = 1'b0;
    logic    cfg_we    = 1'b0;
    half_t   cfg_data  = '0;
    logic    in_ready;
    logic    out_valid;
    sample_t median;

    // Pacing switches, changed per phase so that some stretches run flat out
    bit      send_gaps  = 1'b1;
    bit      recv_stall = 1'b1;
    int      mismatches = 0;

    // Window model: values largest first, ages with 0 the newest
    sample_t window_vals [SLOTS];
    age_t    window_ages [SLOTS];
    half_t   half_reg;
    sample_t median_queue [$];
    sample_t want;

    always #5 clk = ~clk;

    sliding_window_median_filter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Half window in use, saturated at the maximum
    function automatic int active_half();
        return (int'(half_reg) > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : int'(half_reg);
    endfunction

    // Whole window set to one value, ages in slot order
    function automatic void fill_window(input sample_t v);
        int len;
        len = 2 * active_half() + 1;
        for (int i = 0; i < SLOTS; i++)
        begin
            window_vals[i] = (i < len) ? v : '0;
            window_ages[i] = (i < len) ? age_t'(len - 1 - i) : '0;
        end
    endfunction

    // Drop the oldest sample, insert the new one below equal values, return median
    function automatic sample_t filter_sample(input sample_t v);
        int len;
        int oldest;
        int pos;
        len    = 2 * active_half() + 1;
        oldest = 0;
        for (int i = 1; i < len; i++)
            if (window_ages[i] > window_ages[oldest])
                oldest = i;
        for (int i = oldest; i + 1 < len; i++)
        begin
            window_vals[i] = window_vals[i+1];
            window_ages[i] = window_ages[i+1];
        end
        for (int i = 0; i + 1 < len; i++)
            if (window_ages[i] < AGE_MAX)
                window_ages[i] = window_ages[i] + age_t'(1);
        pos = 0;
        while (pos + 1 < len && !(v > window_vals[pos]))
            pos++;
        for (int i = len - 1; i > pos; i--)
        begin
            window_vals[i] = window_vals[i-1];
            window_ages[i] = window_ages[i-1];
        end
        window_vals[pos] = v;
        window_ages[pos] = '0;
        return window_vals[active_half()];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    // Monitor: track config writes, predict on input transactions, check outputs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            half_reg = half_t'(HALF_RESET);
            fill_window('0);
            median_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                half_reg = cfg_data;
                fill_window('0);
            end
            if (in_valid && in_ready)
            begin
                if (func == FUNC_PRIME)
                begin
                    fill_window(sample);
                    median_queue.push_back(sample);
                end
                else
                    median_queue.push_back(filter_sample(sample));
            end
            if (out_valid && out_ready)
            begin
                if (median_queue.size() == 0)
                    report_mismatch($sformatf("unexpected result median=%0d", median));
                else
                begin
                    want = median_queue.pop_front();
                    if (median !== want)
                        report_mismatch($sformatf("median got %0d want %0d", median, want));
                end
            end
        end
    end

    // Receiver: random stall before taking each result
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = recv_stall ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // One input transaction; valid stays up when the next one follows at once
    task automatic send_item(input logic f, input sample_t s);
        int unsigned gap;
        gap = send_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (median_queue.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_half(input half_t v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Reset window of zeros at the default length
    task automatic test_after_reset();
        send_item(FUNC_FILTER, 24'sd5);
        send_item(FUNC_FILTER, -24'sd3);
        send_item(FUNC_FILTER, 24'sd7);
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
    endtask

    // Window of one: median is the sample just filtered
    task automatic test_window_of_one();
        write_half('0);
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
        send_item(FUNC_FILTER, -24'sd1);
        send_item(FUNC_PRIME, 24'sd9);
    endtask

    // Equal values: new sample goes below its equals, eviction by age
    task automatic test_equal_values();
        write_half(half_t'(1));
        send_item(FUNC_PRIME, 24'sd10);
        send_item(FUNC_FILTER, 24'sd10);
        send_item(FUNC_FILTER, 24'sd3);
        send_item(FUNC_FILTER, 24'sd10);
        send_item(FUNC_FILTER, 24'sd3);
        send_item(FUNC_FILTER, 24'sd3);
    endtask

    // Half window above the maximum saturates; extremes through the full window
    task automatic test_saturation();
        write_half('1);
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
        send_item(FUNC_PRIME, SAMPLE_MIN);
        for (int i = 0; i < 17; i++)
            send_item(FUNC_FILTER, (i < 16) ? SAMPLE_MAX : 24'sd0);
        write_half(half_t'(MAX_HALF_WINDOW));
        send_item(FUNC_PRIME, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
    endtask

    // Random phases over many window lengths, mostly primed, mixed sample styles
    task automatic test_random();
        int    sent;
        int    phase;
        int    phase_len;
        int    style;
        int    k;
        half_t h;
        sample_t s;
        logic    f;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       h = '0;
                1:       h = half_t'(MAX_HALF_WINDOW);
                2:       h = '1;
                3:       h = half_t'(1);
                default: h = half_t'($urandom_range(0, 31));
            endcase
            write_half(h);
            send_gaps  = ($urandom_range(0, 3) != 0);
            recv_stall = ($urandom_range(0, 3) != 0);
            style      = $urandom_range(0, 2);
            phase_len  = $urandom_range(60, 200);
            if ($urandom_range(0, 4) != 0)
            begin
                send_item(FUNC_PRIME, sample_t'($urandom));
                sent++;
            end
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                f = ($urandom_range(0, 39) == 0) ? FUNC_PRIME : FUNC_FILTER;
                case (style)
                    0: s = sample_t'($urandom);
                    1:
                    begin
                        k = $urandom_range(0, 8);
                        s = sample_t'(k - 4);
                    end
                    default:
                    begin
                        case ($urandom_range(0, 5))
                            0:       s = SAMPLE_MAX;
                            1:       s = SAMPLE_MIN;
                            2:       s = '0;
                            3:       s = '1;
                            4:       s = sample_t'(1);
                            default: s = sample_t'($urandom);
                        endcase
                    end
                endcase
                send_item(f, s);
                sent++;
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_window_of_one();
        test_equal_values();
        test_saturation();
        test_random();
        drain();
        repeat (5) @(posedge clk);
        if (median_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", median_queue.size()));
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

[sliding_window_median_filter_unit.f]
rtl/swmf_pkg.sv
rtl/swmf_cell.sv
rtl/sliding_window_median_filter_unit.sv
sim/tb.sv
